// File: rtl/tmh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tmh_pkg
// Shared types, constants and helpers for the timer min-heap core.
// ---------------------------------------------------------------------------
package tmh_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [15:0] WINDOW_RESET = 16'd300;

   localparam logic [1:0] FUNC_INSERT  = 2'd0;
   localparam logic [1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [1:0] FUNC_REFRESH = 2'd2;
   localparam logic [1:0] FUNC_EXPIRE  = 2'd3;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_BAD_POS = 3'd2;
   localparam logic [2:0] ST_EXPIRED = 3'd3;
   localparam logic [2:0] ST_NONE    = 3'd4;

   typedef struct packed {
      logic [47:0] expiry;
      logic [15:0] id;
      logic [31:0] ivl;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? {48{1'b1}} : s[47:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/tmh_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tmh_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module tmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// File: rtl/timer_min_heap_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// timer_min_heap_core
// Binary min-heap timer queue: insert, remove at position, refresh by id,
// expire. Entries live in one RAM; a sequencer does read-modify-write sifts.
// ---------------------------------------------------------------------------
// channel   direction  ports                          handshake
// req       in         req_func/timer_id/interval/...  start & !busy
// rsp       out        rsp_status/.../rsp_last         rsp_strobe, one cycle
// csr       in         csr_wdata (refresh_window)      csr_we
//
// Insert sifts the new entry up one heap level at a time; remove moves
// the tail entry into the slot, then sifts it up or down level by level.
// Expire scans all entries, then pops each expired root and sifts down.
// Refresh scans and rearms matches; if any, heapify sifts each parent down.
// All steps share one RAM read port. Reset zeroes count, sets window to 300.
// Results cannot be stalled; busy stays high until the sequencer is done.
// ---------------------------------------------------------------------------
module timer_min_heap_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_timer_id,
   input  wire logic [31:0] req_interval,
   input  wire logic [5:0]  req_position,
   input  wire logic [47:0] req_now_time,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_timer_id_out,
   output logic [47:0]      rsp_expiry_out,
   output logic [6:0]       rsp_count,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   import tmh_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_UP_RD = 5'd1;
   localparam logic [4:0] S_UP_EV = 5'd2;
   localparam logic [4:0] S_DN_RL = 5'd3;
   localparam logic [4:0] S_DN_RR = 5'd4;
   localparam logic [4:0] S_DN_EV = 5'd5;
   localparam logic [4:0] S_REM   = 5'd6;
   localparam logic [4:0] S_REM_X = 5'd7;
   localparam logic [4:0] S_REM_P = 5'd8;
   localparam logic [4:0] S_SC_RD = 5'd9;
   localparam logic [4:0] S_SC_EV = 5'd10;
   localparam logic [4:0] S_SC_EN = 5'd11;
   localparam logic [4:0] S_POP_R = 5'd12;
   localparam logic [4:0] S_POP_E = 5'd13;
   localparam logic [4:0] S_POP_X = 5'd14;
   localparam logic [4:0] S_RF_RD = 5'd15;
   localparam logic [4:0] S_RF_EV = 5'd16;
   localparam logic [4:0] S_RF_EN = 5'd17;
   localparam logic [4:0] S_HP_RD = 5'd18;
   localparam logic [4:0] S_HP_X  = 5'd19;
   localparam logic [4:0] S_DONE  = 5'd20;
   localparam logic [4:0] S_INS   = 5'd21;

   logic [4:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      win_ff, win_in;
   entry_type        x_ff, x_in;
   entry_type        left_ff, left_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] fin_ff, fin_in;
   logic             hasr_ff, hasr_in;
   logic             any_ff, any_in;
   logic [47:0]      now_ff, now_in;
   logic [15:0]      tid_ff, tid_in;
   logic [31:0]      ivl_ff, ivl_in;
   logic [5:0]       pos_ff, pos_in;
   logic [2:0]       st_ff, st_in;

   logic             strobe_ff, strobe_in;
   logic [2:0]       ostat_ff, ostat_in;
   logic [15:0]      oid_ff, oid_in;
   logic [47:0]      oexp_ff, oexp_in;
   logic [6:0]       ocnt_ff, ocnt_in;
   logic             olast_ff, olast_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   entry_type        ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type        rd_e;

   logic [IDX_W:0]   lchild;
   logic [IDX_W:0]   rchild;
   logic [IDX_W-1:0] parent;
   logic [47:0]      diff;
   logic             hit;
   entry_type        child;
   logic [IDX_W-1:0] child_idx;

   tmh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_e   = entry_type'(ram_rdata);
   assign lchild = {i_ff, 1'b1};
   assign rchild = lchild + (IDX_W+1)'(1);
   assign parent = (i_ff - IDX_W'(1)) >> 1;
   assign diff   = rd_e.expiry - now_ff;
   assign hit    = (rd_e.id == tid_ff) && (rd_e.expiry >= now_ff)
                   && (diff < {32'd0, win_ff});

   always_comb begin
      if (hasr_ff && !(left_ff.expiry < rd_e.expiry)) begin
         child     = rd_e;
         child_idx = rchild[IDX_W-1:0];
      end else begin
         child     = left_ff;
         child_idx = lchild[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      win_in    = csr_we ? csr_wdata : win_ff;
      x_in      = x_ff;
      left_in   = left_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      fin_in    = fin_ff;
      hasr_in   = hasr_ff;
      any_in    = any_ff;
      now_in    = now_ff;
      tid_in    = tid_ff;
      ivl_in    = ivl_ff;
      pos_in    = pos_ff;
      st_in     = st_ff;
      strobe_in = 1'b0;
      ostat_in  = ostat_ff;
      oid_in    = oid_ff;
      oexp_in   = oexp_ff;
      ocnt_in   = ocnt_ff;
      olast_in  = olast_ff;
      ram_we    = 1'b0;
      ram_waddr = i_ff;
      ram_wdata = x_ff;
      ram_raddr = i_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_func;
               now_in = req_now_time;
               tid_in = req_timer_id;
               ivl_in = req_interval;
               pos_in = req_position;
               st_in  = ST_DONE;
               i_in   = '0;
               k_in   = '0;
               any_in = 1'b0;
               case (req_func)
                  FUNC_INSERT:  state_in = S_INS;
                  FUNC_REMOVE:  state_in = S_REM;
                  FUNC_REFRESH: state_in = S_RF_RD;
                  default:      state_in = S_SC_RD;
               endcase
            end
         end
         S_INS: begin
            if (cnt_ff == CNT_W'(CAPACITY)) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else begin
               x_in     = '{expiry: sat_add(now_ff, ivl_ff), id: tid_ff, ivl: ivl_ff};
               i_in     = cnt_ff[IDX_W-1:0];
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = S_UP_RD;
            end
         end
         S_UP_RD: begin
            if (i_ff == '0) begin
               ram_we   = 1'b1;
               state_in = S_DONE;
            end else begin
               ram_raddr = parent;
               state_in  = S_UP_EV;
            end
         end
         S_UP_EV: begin
            ram_we = 1'b1;
            if (x_ff.expiry < rd_e.expiry) begin
               ram_wdata = rd_e;
               i_in      = parent;
               state_in  = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN_RL: begin
            if ({1'b0, lchild} >= {{(IDX_W+2-CNT_W){1'b0}}, cnt_ff}) begin
               ram_we = 1'b1;
               case (op_ff)
                  FUNC_EXPIRE:  state_in = (k_ff == '0) ? S_IDLE : S_POP_R;
                  FUNC_REFRESH: state_in = S_HP_RD;
                  default:      state_in = S_DONE;
               endcase
            end else begin
               ram_raddr = lchild[IDX_W-1:0];
               state_in  = S_DN_RR;
            end
         end
         S_DN_RR: begin
            left_in   = rd_e;
            hasr_in   = {1'b0, rchild} < {{(IDX_W+2-CNT_W){1'b0}}, cnt_ff};
            ram_raddr = rchild[IDX_W-1:0];
            state_in  = S_DN_EV;
         end
         S_DN_EV: begin
            ram_we = 1'b1;
            if (x_ff.expiry < child.expiry) begin
               case (op_ff)
                  FUNC_EXPIRE:  state_in = (k_ff == '0) ? S_IDLE : S_POP_R;
                  FUNC_REFRESH: state_in = S_HP_RD;
                  default:      state_in = S_DONE;
               endcase
            end else begin
               ram_wdata = child;
               i_in      = child_idx;
               state_in  = S_DN_RL;
            end
         end
         S_REM: begin
            if ({2'b00, pos_ff} >= {{(8-CNT_W){1'b0}}, cnt_ff}) begin
               st_in    = ST_BAD_POS;
               state_in = S_DONE;
            end else if ({2'b00, pos_ff} == {{(8-CNT_W){1'b0}}, cnt_ff - CNT_W'(1)}) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_DONE;
            end else begin
               ram_raddr = IDX_W'(cnt_ff - CNT_W'(1));
               i_in      = IDX_W'(pos_ff);
               state_in  = S_REM_X;
            end
         end
         S_REM_X: begin
            x_in   = rd_e;
            cnt_in = cnt_ff - CNT_W'(1);
            if (i_ff == '0) begin
               state_in = S_DN_RL;
            end else begin
               ram_raddr = parent;
               state_in  = S_REM_P;
            end
         end
         S_REM_P: begin
            if (x_ff.expiry < rd_e.expiry) begin
               ram_we    = 1'b1;
               ram_wdata = rd_e;
               i_in      = parent;
               state_in  = S_UP_RD;
            end else begin
               state_in = S_DN_RL;
            end
         end
         S_SC_RD: begin
            if ({1'b0, i_ff} >= cnt_ff || cnt_ff == '0) begin
               state_in = S_SC_EN;
            end else begin
               state_in = S_SC_EV;
            end
         end
         S_SC_EV: begin
            if (rd_e.expiry <= now_ff) begin
               k_in = k_ff + CNT_W'(1);
            end
            if ({1'b0, i_ff} == cnt_ff - CNT_W'(1)) begin
               state_in = S_SC_EN;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_SC_RD;
            end
         end
         S_SC_EN: begin
            if (k_ff == '0) begin
               st_in    = ST_NONE;
               state_in = S_DONE;
            end else begin
               fin_in   = cnt_ff - k_ff;
               state_in = S_POP_R;
            end
         end
         S_POP_R: begin
            ram_raddr = '0;
            state_in  = S_POP_E;
         end
         S_POP_E: begin
            strobe_in = 1'b1;
            ostat_in  = ST_EXPIRED;
            oid_in    = rd_e.id;
            oexp_in   = rd_e.expiry;
            ocnt_in   = 7'(fin_ff);
            olast_in  = (k_ff == CNT_W'(1));
            k_in      = k_ff - CNT_W'(1);
            i_in      = '0;
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               ram_raddr = IDX_W'(cnt_ff - CNT_W'(1));
               state_in  = S_POP_X;
            end
         end
         S_POP_X: begin
            x_in     = rd_e;
            cnt_in   = cnt_ff - CNT_W'(1);
            state_in = S_DN_RL;
         end
         S_RF_RD: begin
            if ({1'b0, i_ff} >= cnt_ff || cnt_ff == '0) begin
               state_in = S_RF_EN;
            end else begin
               state_in = S_RF_EV;
            end
         end
         S_RF_EV: begin
            if (hit) begin
               ram_we    = 1'b1;
               ram_wdata = '{expiry: sat_add(now_ff, rd_e.ivl), id: rd_e.id, ivl: rd_e.ivl};
               any_in    = 1'b1;
            end
            if ({1'b0, i_ff} == cnt_ff - CNT_W'(1)) begin
               state_in = S_RF_EN;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_RF_RD;
            end
         end
         S_RF_EN: begin
            j_in     = cnt_ff >> 1;
            state_in = any_ff ? S_HP_RD : S_DONE;
         end
         S_HP_RD: begin
            if (j_ff == '0) begin
               state_in = S_DONE;
            end else begin
               ram_raddr = IDX_W'(j_ff - CNT_W'(1));
               i_in      = IDX_W'(j_ff - CNT_W'(1));
               j_in      = j_ff - CNT_W'(1);
               state_in  = S_HP_X;
            end
         end
         S_HP_X: begin
            x_in     = rd_e;
            state_in = S_DN_RL;
         end
         S_DONE: begin
            strobe_in = 1'b1;
            ostat_in  = st_ff;
            oid_in    = '0;
            oexp_in   = '0;
            ocnt_in   = 7'(cnt_ff);
            olast_in  = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         win_ff    <= WINDOW_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         win_ff    <= win_in;
         strobe_ff <= strobe_in;
      end
      op_ff    <= op_in;
      x_ff     <= x_in;
      left_ff  <= left_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      fin_ff   <= fin_in;
      hasr_ff  <= hasr_in;
      any_ff   <= any_in;
      now_ff   <= now_in;
      tid_ff   <= tid_in;
      ivl_ff   <= ivl_in;
      pos_ff   <= pos_in;
      st_ff    <= st_in;
      ostat_ff <= ostat_in;
      oid_ff   <= oid_in;
      oexp_ff  <= oexp_in;
      ocnt_ff  <= ocnt_in;
      olast_ff <= olast_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = ostat_ff;
   assign rsp_timer_id_out = oid_ff;
   assign rsp_expiry_out   = oexp_ff;
   assign rsp_count        = ocnt_ff;
   assign rsp_last         = olast_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_EXPIRED) |-> rsp_last)
      else $error("non-expire transaction without last");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !start) |=> (state_ff == S_IDLE))
      else $error("sequencer left idle without a transaction");

endmodule
`default_nettype wire

// File: bench/timer_min_heap_core_test.sv
// ---------------------------------------------------------------------------
// timer_min_heap_core_test
// Self-checking bench for the timer min-heap core. A heap tracker inside a
// small scoreboard class predicts every response transaction from the
// accepted requests; directed and random requests run under several
// refresh window settings, including filling the heap and draining it.
// ---------------------------------------------------------------------------
module timer_min_heap_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tmh_pkg::*;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] tid;
      logic [47:0] expiry;
      logic [6:0]  count;
      logic        last;
   } outcome_type;

   class heap_scoreboard;
      logic [47:0] exp_q[CAPACITY];
      logic [15:0] id_q[CAPACITY];
      logic [31:0] ivl_q[CAPACITY];
      int          held;
      logic [15:0] window;
      outcome_type due[$];
      int          errors;

      function new();
         held   = 0;
         window = WINDOW_RESET;
         errors = 0;
      endfunction

      function logic [47:0] arm(input logic [47:0] t, input logic [31:0] d);
         logic [48:0] s;
         s = {1'b0, t} + {17'd0, d};
         return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
      endfunction

      function void swap(input int a, input int b);
         logic [47:0] e;
         logic [15:0] d;
         logic [31:0] v;
         e = exp_q[a]; d = id_q[a]; v = ivl_q[a];
         exp_q[a] = exp_q[b]; id_q[a] = id_q[b]; ivl_q[a] = ivl_q[b];
         exp_q[b] = e; id_q[b] = d; ivl_q[b] = v;
      endfunction

      function void bubble_up(input int i);
         while (i > 0 && exp_q[i] < exp_q[(i - 1) / 2]) begin
            swap(i, (i - 1) / 2);
            i = (i - 1) / 2;
         end
      endfunction

      function void bubble_down(input int i);
         int l, m;
         l = 2 * i + 1;
         while (l < held) begin
            m = (l + 1 == held || exp_q[l] < exp_q[l + 1]) ? l : l + 1;
            if (exp_q[i] < exp_q[m]) break;
            swap(i, m);
            i = m;
            l = 2 * i + 1;
         end
      endfunction

      function void drop(input int i);
         int tail;
         tail = held - 1;
         if (i == tail) begin
            held = tail;
            return;
         end
         swap(i, tail);
         held = tail;
         if (i > 0 && exp_q[i] < exp_q[(i - 1) / 2]) bubble_up(i);
         else bubble_down(i);
      endfunction

      function void note_request(input logic [1:0] f, input logic [15:0] tid,
                                 input logic [31:0] ivl, input logic [5:0] pos,
                                 input logic [47:0] now);
         outcome_type r[$];
         outcome_type o;
         bit hit[CAPACITY];
         bit any;
         o = '{ST_DONE, 16'd0, 48'd0, 7'd0, 1'b0};
         any = 0;
         case (f)
            FUNC_INSERT: begin
               if (held >= CAPACITY) o.status = ST_FULL;
               else begin
                  exp_q[held] = arm(now, ivl);
                  id_q[held]  = tid;
                  ivl_q[held] = ivl;
                  held++;
                  bubble_up(held - 1);
               end
               r = {r, o};
            end
            FUNC_REMOVE: begin
               if (pos >= held) o.status = ST_BAD_POS;
               else drop(pos);
               r = {r, o};
            end
            FUNC_REFRESH: begin
               for (int i = 0; i < held; i++) begin
                  hit[i] = id_q[i] == tid && exp_q[i] >= now &&
                           (exp_q[i] - now) < {32'd0, window};
                  any |= hit[i];
               end
               if (any) begin
                  for (int i = 0; i < held; i++)
                     if (hit[i]) exp_q[i] = arm(now, ivl_q[i]);
                  for (int i = held / 2; i > 0; i--) bubble_down(i - 1);
               end
               r = {r, o};
            end
            default: begin
               while (held > 0 && exp_q[0] <= now) begin
                  o.status = ST_EXPIRED;
                  o.tid    = id_q[0];
                  o.expiry = exp_q[0];
                  r = {r, o};
                  drop(0);
               end
               if (r.size() == 0) begin
                  o.status = ST_NONE;
                  r = {r, o};
               end
            end
         endcase
         foreach (r[k]) begin
            r[k].count = held[6:0];
            r[k].last  = (k == r.size() - 1);
            due = {due, r[k]};
         end
      endfunction

      function void check_result(input outcome_type got);
         outcome_type w;
         if (due.size() == 0) begin
            $display("%0t: unexpected response, status %0d", $time, got.status);
            errors++;
            return;
         end
         w = due.pop_front();
         if (got.status !== w.status) begin
            $display("%0t: status exp %0d got %0d", $time, w.status, got.status);
            errors++;
         end
         if (got.tid !== w.tid) begin
            $display("%0t: timer_id exp %h got %h", $time, w.tid, got.tid);
            errors++;
         end
         if (got.expiry !== w.expiry) begin
            $display("%0t: expiry exp %h got %h", $time, w.expiry, got.expiry);
            errors++;
         end
         if (got.count !== w.count) begin
            $display("%0t: count exp %0d got %0d", $time, w.count, got.count);
            errors++;
         end
         if (got.last !== w.last) begin
            $display("%0t: last exp %0d got %0d", $time, w.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_func = FUNC_INSERT;
   logic [15:0] req_timer_id = '0;
   logic [31:0] req_interval = '0;
   logic [5:0]  req_position = '0;
   logic [47:0] req_now_time = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_timer_id_out;
   logic [47:0] rsp_expiry_out;
   logic [6:0]  rsp_count;
   logic        rsp_last;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = '0;

   heap_scoreboard sb = new();
   logic [47:0] clk_now = 48'd1000;
   bit          gaps = 1;

   timer_min_heap_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_timer_id(req_timer_id),
      .req_interval(req_interval), .req_position(req_position),
      .req_now_time(req_now_time),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_timer_id_out(rsp_timer_id_out), .rsp_expiry_out(rsp_expiry_out),
      .rsp_count(rsp_count), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result('{rsp_status, rsp_timer_id_out, rsp_expiry_out,
                           rsp_count, rsp_last});
   end

   task automatic send(input logic [1:0] f, input logic [15:0] tid,
                       input logic [31:0] ivl, input logic [5:0] pos,
                       input logic [47:0] now);
      if (gaps && $urandom_range(0, 9) < 3) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start        <= 1;
      req_func     <= f;
      req_timer_id <= tid;
      req_interval <= ivl;
      req_position <= pos;
      req_now_time <= now;
      do @(posedge clock); while (busy);
      sb.note_request(f, tid, ivl, pos, now);
   endtask

   task automatic settle();
      start <= 0;
      while (sb.due.size() > 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_window(input logic [15:0] w);
      settle();
      csr_we    <= 1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 0;
      sb.window = w;
   endtask

   task automatic random_item();
      logic [1:0]  f;
      logic [15:0] tid;
      logic [31:0] ivl;
      logic [5:0]  pos;
      logic [47:0] now;
      int          p;
      p = $urandom_range(0, 99);
      f = p < 40 ? FUNC_INSERT : p < 55 ? FUNC_REMOVE : p < 75 ? FUNC_REFRESH : FUNC_EXPIRE;
      clk_now += $urandom_range(0, 150);
      now = clk_now;
      if ($urandom_range(0, 19) == 0) now = 48'({$urandom, $urandom});
      tid = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7));
      ivl = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 600);
      pos = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, sb.held));
      send(f, tid, ivl, pos, now);
   endtask

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset window
      send(FUNC_EXPIRE, 0, 0, 0, 0);
      send(FUNC_REMOVE, 0, 0, 0, 0);
      send(FUNC_INSERT, 16'h0000, 32'd0, 0, 48'd0);
      send(FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 63, 48'hFFFF_FFFF_FFFF);
      send(FUNC_INSERT, 16'h0005, 32'd100, 0, 48'd1000);
      send(FUNC_INSERT, 16'h0005, 32'd250, 0, 48'd1000);
      send(FUNC_INSERT, 16'h0006, 32'd50, 0, 48'd1000);
      send(FUNC_REFRESH, 16'h0005, 0, 0, 48'd1010);
      send(FUNC_REFRESH, 16'h0000, 0, 0, 48'd1010);
      send(FUNC_REMOVE, 0, 0, 63, 0);
      send(FUNC_REMOVE, 0, 0, 5, 0);
      send(FUNC_REMOVE, 0, 0, 1, 0);
      send(FUNC_EXPIRE, 0, 0, 0, 48'd1060);
      send(FUNC_EXPIRE, 0, 0, 0, 48'd999);
      send(FUNC_EXPIRE, 0, 0, 0, 48'hFFFF_FFFF_FFFE);
      send(FUNC_EXPIRE, 0, 0, 0, 48'hFFFF_FFFF_FFFF);

      set_window(16'd0);
      for (int n = 0; n < 12; n++) random_item();

      set_window(16'hFFFF);
      for (int n = 0; n < 6; n++) random_item();
      while (sb.held < CAPACITY)
         send(FUNC_INSERT, 16'($urandom_range(0, 7)), $urandom_range(0, 5000), 0, clk_now);
      send(FUNC_INSERT, 16'd1, 32'd1, 0, clk_now);
      send(FUNC_REFRESH, 16'd1, 0, 0, clk_now + 48'd10);
      send(FUNC_REMOVE, 0, 0, 63, 0);
      send(FUNC_INSERT, 16'd2, 32'd2, 0, clk_now);
      send(FUNC_EXPIRE, 0, 0, 0, 48'hFFFF_FFFF_FFFF);

      set_window(16'($urandom));
      for (int n = 0; n < 10; n++) random_item();

      set_window(WINDOW_RESET);
      gaps = 0;
      for (int n = 0; n < 8; n++) random_item();

      settle();
      if (sb.errors == 0 && sb.due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tmh_pkg.sv
rtl/tmh_ram.sv
rtl/timer_min_heap_core.sv
bench/timer_min_heap_core_test.sv
